[design/i8mvrs_pkg.sv]
// Shared types and constants for the int8 weight matvec core with per-row scale.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package i8mvrs_pkg;

  localparam int ColsW     = 13;
  localparam int ColsReset = 4096;
  localparam int ActIdxW   = 12;
  localparam int ActW      = 32;
  localparam int WeightW   = 8;
  localparam int ScaleW    = 32;
  localparam int OutW      = 32;
  localparam int RowW      = 16;
  localparam int AccW      = 56;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_SCL_LO,
    ST_SCL_HI,
    ST_SUM,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic take;
    logic load;
    logic mul;
    logic acc;
    logic scl_lo;
    logic scl_hi;
    logic sum;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic row_end;
  } dp_status_t;

endpackage

`default_nettype wire

[design/i8mvrs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module i8mvrs_ram #(
  parameter int Width = 32,
  parameter int Depth = 4096,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[design/i8mvrs_ctrl.sv]
// Controller FSM: sequences request intake, multiply-accumulate and row scaling.
// Depends on i8mvrs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i8mvrs_ctrl import i8mvrs_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       func_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  input  wire dp_status_t status_i,
  output dp_cmd_t         cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q & ~out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (func_i) begin
            cmd_o.take = 1'b1;
            state_d    = ST_MUL;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = status_i.row_end ? ST_SCL_LO : ST_IDLE;
      end
      ST_SCL_LO: begin
        cmd_o.scl_lo = 1'b1;
        state_d      = ST_SCL_HI;
      end
      ST_SCL_HI: begin
        cmd_o.scl_hi = 1'b1;
        state_d      = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

[design/i8mvrs_dp.sv]
// Datapath: activation store, column/row counters, MAC and row scaling with saturation.
// Depends on i8mvrs_pkg and i8mvrs_ram.
`timescale 1ns / 1ps
`default_nettype none

module i8mvrs_dp import i8mvrs_pkg::*; #(
  parameter int MAX_COLS = 4096
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic        [ColsW-1:0]   cfg_wdata_i,
  input  wire logic        [ActIdxW-1:0] act_index_i,
  input  wire logic signed [ActW-1:0]    act_value_i,
  input  wire logic signed [WeightW-1:0] weight_i,
  input  wire logic signed [ScaleW-1:0]  row_scale_i,
  input  wire dp_cmd_t                   cmd_i,
  output dp_status_t                     status_o,
  output logic signed      [OutW-1:0]    out_value_o,
  output logic             [RowW-1:0]    row_number_o
);

  localparam int AW      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CntW    = $clog2(MAX_COLS + 1);
  localparam int CmpW    = (CntW > ColsW) ? CntW : ColsW;
  localparam int IdxW    = ((AW > ActIdxW) ? AW : ActIdxW) + 1;
  localparam int DefCols = (MAX_COLS < ColsReset) ? MAX_COLS : ColsReset;
  localparam int HalfW   = AccW / 2;
  localparam int ProdW   = WeightW + ActW;
  localparam int PpW     = HalfW + 1 + ScaleW;
  localparam int FullW   = AccW + ScaleW;
  localparam int QW      = FullW - 16;

  // configuration: last column index, clamped
  logic [AW-1:0]   last_col_q, last_col_d;
  logic [CmpW-1:0] cfg_ext, cfg_m1;

  assign cfg_ext = CmpW'(cfg_wdata_i);
  assign cfg_m1  = cfg_ext - CmpW'(1);

  always_comb begin
    priority if (cfg_wdata_i == '0) begin
      last_col_d = '0;
    end else if (cfg_ext > CmpW'(MAX_COLS)) begin
      last_col_d = AW'(MAX_COLS - 1);
    end else begin
      last_col_d = cfg_m1[AW-1:0];
    end
  end

  // activation store
  logic [IdxW-1:0] idx_ext;
  logic            wr_en;
  logic [AW-1:0]   col_q;
  logic [ActW-1:0] act_rd;

  assign idx_ext = IdxW'(act_index_i);
  assign wr_en   = cmd_i.load && (idx_ext < IdxW'(MAX_COLS));

  i8mvrs_ram #(
    .Width (ActW),
    .Depth (MAX_COLS)
  ) u_act_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (idx_ext[AW-1:0]),
    .wdata_i (act_value_i),
    .raddr_i (col_q),
    .rdata_o (act_rd)
  );

  // control registers
  logic                    row_end_q;
  logic [RowW-1:0]         row_q;
  logic [AccW-1:0]         acc_q;
  logic                    at_last;
  logic signed [ProdW-1:0] prod_q;

  assign at_last = col_q >= last_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_col_q <= AW'(DefCols - 1);
      col_q      <= '0;
      row_q      <= '0;
      acc_q      <= '0;
      row_end_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        last_col_q <= last_col_d;
      end
      if (cmd_i.take) begin
        row_end_q <= at_last;
        col_q     <= at_last ? '0 : col_q + AW'(1);
      end
      if (cmd_i.acc) begin
        acc_q <= acc_q + {{(AccW - ProdW){prod_q[ProdW-1]}}, prod_q};
      end
      if (cmd_i.emit) begin
        row_q <= row_q + RowW'(1);
        acc_q <= '0;
      end
    end
  end

  // payload registers
  logic signed [WeightW-1:0] weight_q;
  logic signed [ScaleW-1:0]  scale_q;
  logic signed [HalfW:0]     mul_a;
  logic signed [PpW-1:0]     mul_p;
  logic signed [PpW-1:0]     pp_lo_q;
  logic signed [PpW-2:0]     pp_hi_q;
  logic signed [FullW-1:0]   sum_q;
  logic signed [OutW-1:0]    out_value_q;
  logic        [RowW-1:0]    row_number_q;
  logic        [QW-1:0]      quot;
  logic                      fits;
  logic signed [OutW-1:0]    sat_val;

  // shared multiplier for the two halves of the accumulator
  assign mul_a = cmd_i.scl_hi ? {acc_q[AccW-1], acc_q[AccW-1:HalfW]}
                              : {1'b0, acc_q[HalfW-1:0]};
  assign mul_p = mul_a * scale_q;

  assign quot    = sum_q[FullW-1:16];
  assign fits    = (&quot[QW-1:OutW-1]) || !(|quot[QW-1:OutW-1]);
  assign sat_val = fits ? quot[OutW-1:0]
                 : (quot[QW-1] ? {1'b1, {(OutW - 1){1'b0}}} : {1'b0, {(OutW - 1){1'b1}}});

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      weight_q <= weight_i;
      scale_q  <= row_scale_i;
    end
    if (cmd_i.mul) begin
      prod_q <= weight_q * $signed(act_rd);
    end
    if (cmd_i.scl_lo) begin
      pp_lo_q <= mul_p;
    end
    if (cmd_i.scl_hi) begin
      pp_hi_q <= mul_p[PpW-2:0];
    end
    if (cmd_i.sum) begin
      sum_q <= {pp_hi_q, {HalfW{1'b0}}} + {{(FullW - PpW){pp_lo_q[PpW-1]}}, pp_lo_q};
    end
    if (cmd_i.emit) begin
      out_value_q  <= sat_val;
      row_number_q <= row_q;
    end
  end

  assign status_o.row_end = row_end_q;
  assign out_value_o      = out_value_q;
  assign row_number_o     = row_number_q;

endmodule

`default_nettype wire

[design/int8_weight_matvec_row_scaled_core.sv]
// int8 weight matvec core, one Q16.16 scale per row.
// Activation load request: done on acceptance. Weight request: accept, RAM read +
// multiply, accumulate; a row's last weight adds a two-pass 29x32 scale multiply on
// one shared multiplier, an 88-bit sum and saturation before the result is posted.
// Row results wait in an output register; new requests are taken while it is full.
// Async active-low reset clears counters, accumulator and handshakes; activation RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module int8_weight_matvec_row_scaled_core import i8mvrs_pkg::*; #(
  parameter int MAX_COLS = 4096
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic        [ColsW-1:0]   cfg_wdata_i,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic                      func_i,
  input  wire logic        [ActIdxW-1:0] act_index_i,
  input  wire logic signed [ActW-1:0]    act_value_i,
  input  wire logic signed [WeightW-1:0] weight_i,
  input  wire logic signed [ScaleW-1:0]  row_scale_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic signed      [OutW-1:0]    out_value_o,
  output logic             [RowW-1:0]    row_number_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  i8mvrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .func_i      (func_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  i8mvrs_dp #(
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .act_index_i  (act_index_i),
    .act_value_i  (act_value_i),
    .weight_i     (weight_i),
    .row_scale_i  (row_scale_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_value_o  (out_value_o),
    .row_number_o (row_number_o)
  );

endmodule

`default_nettype wire
